[hw/rtl/sfcs_pkg.sv]
package sfcs_pkg;

  localparam int unsigned SECTOR_BYTES = 4096;
  localparam int unsigned SECTOR_COUNT = 2048;
  localparam int unsigned PAGE_BYTES   = 256;

  localparam int unsigned ADDR_W       = 23;
  localparam int unsigned COUNT_W      = 24;
  localparam int unsigned SECTOR_W     = 12;
  localparam int unsigned SECTOR_SHIFT = $clog2(SECTOR_BYTES);
  localparam int unsigned SIZE_W       = 33;

  localparam logic [SIZE_W-1:0] FLASH_BYTES =
    SIZE_W'(SECTOR_BYTES) * SIZE_W'(SECTOR_COUNT);

  localparam logic [7:0] OPC_WREN   = 8'h06;
  localparam logic [7:0] OPC_RDSR   = 8'h05;
  localparam logic [7:0] OPC_READ   = 8'h03;
  localparam logic [7:0] OPC_PROG   = 8'h02;
  localparam logic [7:0] OPC_SERASE = 8'h20;
  localparam logic [7:0] OPC_CERASE = 8'hC7;
  localparam logic [7:0] FILL_BYTE  = 8'hA5;

  typedef enum logic [1:0] {
    OP_READ   = 2'd0,
    OP_PROG   = 2'd1,
    OP_SERASE = 2'd2,
    OP_CERASE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_BUSY     = 2'd0,
    ST_REJECTED = 2'd1,
    ST_DONE     = 2'd2,
    ST_IGNORED  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_WREN   = 4'd1,
    PH_HDR    = 4'd2,
    PH_READ   = 4'd3,
    PH_PDATA  = 4'd4,
    PH_FEND   = 4'd5,
    PH_WCMD   = 4'd6,
    PH_WPOLL  = 4'd7,
    PH_REOPEN = 4'd8
  } phase_e;

  typedef struct packed {
    logic                mode;
    logic [1:0]          op;
    logic [ADDR_W-1:0]   addr;
    logic [SECTOR_W-1:0] sector;
    logic [COUNT_W-1:0]  count;
    logic [7:0]          rx_byte;
    logic [7:0]          wr_data;
  } req_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       cs_release;
    logic       need_data;
    logic       read_valid;
    logic [7:0] rd_data;
    status_e    status;
  } rsp_t;

  function automatic logic [7:0] opcode_of(logic [1:0] kind);
    logic [7:0] opc;
    case (kind)
      OP_READ:   opc = OPC_READ;
      OP_PROG:   opc = OPC_PROG;
      OP_SERASE: opc = OPC_SERASE;
      default:   opc = OPC_CERASE;
    endcase
    return opc;
  endfunction

endpackage

[hw/rtl/sfcs_if.sv]
interface sfcs_req_if;
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [1:0]                    op;
  logic [sfcs_pkg::ADDR_W-1:0]   addr;
  logic [sfcs_pkg::SECTOR_W-1:0] sector;
  logic [sfcs_pkg::COUNT_W-1:0]  count;
  logic [7:0]                    rx_byte;
  logic [7:0]                    wr_data;

  modport source (output valid, mode, op, addr, sector, count, rx_byte, wr_data,
                  input ready);
  modport sink (input valid, mode, op, addr, sector, count, rx_byte, wr_data,
                output ready);
endinterface

interface sfcs_rsp_if;
  logic       valid;
  logic       ready;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       cs_release;
  logic       need_data;
  logic       read_valid;
  logic [7:0] rd_data;
  logic [1:0] status;

  modport source (output valid, tx_valid, tx_byte, cs_release, need_data,
                  read_valid, rd_data, status, input ready);
  modport sink (input valid, tx_valid, tx_byte, cs_release, need_data,
                read_valid, rd_data, status, output ready);
endinterface

[hw/rtl/spi_flash_command_sequencer_unit.sv]
// Pipeline: a request is held in the request register, and its result is then
// loaded into the result register; a stalled response holds both stages.
// Throughput: one request per cycle while the response is taken; the state update
// is a single pass of logic between the two registers.
// Reset: asynchronous, active low; phase returns to idle, command state
// clears and both register stages empty.
module spi_flash_command_sequencer_unit #(
  parameter int unsigned SECTOR_BYTES = sfcs_pkg::SECTOR_BYTES,
  parameter int unsigned SECTOR_COUNT = sfcs_pkg::SECTOR_COUNT,
  parameter int unsigned PAGE_BYTES   = sfcs_pkg::PAGE_BYTES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sfcs_req_if.sink    req_i,
  sfcs_rsp_if.source  rsp_o
);

  localparam int unsigned AW = sfcs_pkg::ADDR_W;
  localparam int unsigned CW = sfcs_pkg::COUNT_W;
  localparam int unsigned SW = sfcs_pkg::SIZE_W;

  localparam int unsigned SECTOR_SHIFT = $clog2(SECTOR_BYTES);
  localparam int unsigned PAGE_SHIFT   = $clog2(PAGE_BYTES);
  localparam logic [SW-1:0] FLASH_BYTES = SW'(SECTOR_BYTES) * SW'(SECTOR_COUNT);

  logic             in_vld_q;
  sfcs_pkg::req_t   in_q;
  logic             out_vld_q;
  sfcs_pkg::rsp_t   out_q;
  logic             adv;
  logic             fire;
  sfcs_pkg::rsp_t   res_d;

  sfcs_pkg::phase_e phase_q, phase_d;
  logic [1:0]       cmd_kind_q, cmd_kind_d;
  logic [AW-1:0]    cur_addr_q, cur_addr_d;
  logic [CW-1:0]    bytes_left_q, bytes_left_d;
  logic [1:0]       hdr_index_q, hdr_index_d;

  logic [CW-1:0]    bl_dec;
  logic [AW-1:0]    addr_inc;
  logic [1:0]       hdr_inc;
  logic             data_last;
  logic             busy;
  logic             range_bad;
  logic             sector_bad;
  logic [AW-1:0]    sector_addr;
  logic             bl_zero;
  logic             prog_more;

  // pipeline handshake
  assign adv         = !out_vld_q || rsp_o.ready;
  assign fire        = in_vld_q && adv;
  assign req_i.ready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (req_i.ready) begin
      in_vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      in_q.mode    <= req_i.mode;
      in_q.op      <= req_i.op;
      in_q.addr    <= req_i.addr;
      in_q.sector  <= req_i.sector;
      in_q.count   <= req_i.count;
      in_q.rx_byte <= req_i.rx_byte;
      in_q.wr_data <= req_i.wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= sfcs_pkg::PH_IDLE;
      cmd_kind_q   <= '0;
      cur_addr_q   <= '0;
      bytes_left_q <= '0;
      hdr_index_q  <= '0;
    end else if (fire) begin
      phase_q      <= phase_d;
      cmd_kind_q   <= cmd_kind_d;
      cur_addr_q   <= cur_addr_d;
      bytes_left_q <= bytes_left_d;
      hdr_index_q  <= hdr_index_d;
    end
  end

  // shared terms
  assign bl_dec      = bytes_left_q - CW'(1);
  assign addr_inc    = cur_addr_q + AW'(1);
  assign hdr_inc     = hdr_index_q + 2'd1;
  assign data_last   = (bl_dec == '0) || (addr_inc[PAGE_SHIFT-1:0] == '0);
  assign busy        = phase_q != sfcs_pkg::PH_IDLE;
  assign range_bad   = (SW'(in_q.addr) + SW'(in_q.count)) > FLASH_BYTES;
  assign sector_bad  = SW'(in_q.sector) >= SW'(SECTOR_COUNT);
  assign sector_addr = AW'({in_q.sector, {SECTOR_SHIFT{1'b0}}});
  assign bl_zero     = bytes_left_q == '0;
  assign prog_more   = (cmd_kind_q == sfcs_pkg::OP_PROG) && !bl_zero;

  // next state
  always_comb begin
    phase_d      = phase_q;
    cmd_kind_d   = cmd_kind_q;
    cur_addr_d   = cur_addr_q;
    bytes_left_d = bytes_left_q;
    hdr_index_d  = hdr_index_q;
    if (!in_q.mode) begin
      if (!busy) begin
        case (in_q.op)
          sfcs_pkg::OP_READ, sfcs_pkg::OP_PROG: begin
            if (!range_bad) begin
              cur_addr_d   = in_q.addr;
              bytes_left_d = in_q.count;
              cmd_kind_d   = in_q.op;
              hdr_index_d  = '0;
              phase_d      = (in_q.op == sfcs_pkg::OP_READ) ? sfcs_pkg::PH_HDR
                                                             : sfcs_pkg::PH_WREN;
            end
          end
          sfcs_pkg::OP_SERASE: begin
            if (!sector_bad) begin
              cur_addr_d   = sector_addr;
              bytes_left_d = '0;
              cmd_kind_d   = in_q.op;
              hdr_index_d  = '0;
              phase_d      = sfcs_pkg::PH_WREN;
            end
          end
          default: begin
            cur_addr_d   = '0;
            bytes_left_d = '0;
            cmd_kind_d   = in_q.op;
            hdr_index_d  = '0;
            phase_d      = sfcs_pkg::PH_WREN;
          end
        endcase
      end
    end else begin
      case (phase_q)
        sfcs_pkg::PH_WREN: begin
          hdr_index_d = '0;
          phase_d     = (cmd_kind_q == sfcs_pkg::OP_CERASE) ? sfcs_pkg::PH_FEND
                                                             : sfcs_pkg::PH_HDR;
        end
        sfcs_pkg::PH_HDR: begin
          if (hdr_index_q != 2'd3) begin
            hdr_index_d = hdr_inc;
          end else if (cmd_kind_q == sfcs_pkg::OP_READ) begin
            if (bl_zero) begin
              phase_d = sfcs_pkg::PH_IDLE;
            end else begin
              bytes_left_d = bl_dec;
              phase_d      = sfcs_pkg::PH_READ;
            end
          end else if (prog_more) begin
            bytes_left_d = bl_dec;
            cur_addr_d   = addr_inc;
            phase_d      = data_last ? sfcs_pkg::PH_FEND : sfcs_pkg::PH_PDATA;
          end else begin
            phase_d = sfcs_pkg::PH_WCMD;
          end
        end
        sfcs_pkg::PH_READ: begin
          if (bl_zero) begin
            phase_d = sfcs_pkg::PH_IDLE;
          end else begin
            bytes_left_d = bl_dec;
          end
        end
        sfcs_pkg::PH_PDATA: begin
          bytes_left_d = bl_dec;
          cur_addr_d   = addr_inc;
          phase_d      = data_last ? sfcs_pkg::PH_FEND : sfcs_pkg::PH_PDATA;
        end
        sfcs_pkg::PH_FEND:   phase_d = sfcs_pkg::PH_WCMD;
        sfcs_pkg::PH_WCMD:   phase_d = sfcs_pkg::PH_WPOLL;
        sfcs_pkg::PH_WPOLL: begin
          if (!in_q.rx_byte[0]) begin
            phase_d = prog_more ? sfcs_pkg::PH_REOPEN : sfcs_pkg::PH_IDLE;
          end
        end
        sfcs_pkg::PH_REOPEN: phase_d = sfcs_pkg::PH_WREN;
        default:             phase_d = sfcs_pkg::PH_IDLE;
      endcase
    end
  end

  // result
  always_comb begin
    res_d = '{tx_valid: 1'b0, tx_byte: 8'h00, cs_release: 1'b0, need_data: 1'b0,
              read_valid: 1'b0, rd_data: 8'h00, status: sfcs_pkg::ST_BUSY};
    if (!in_q.mode) begin
      if (busy || (((in_q.op == sfcs_pkg::OP_READ) || (in_q.op == sfcs_pkg::OP_PROG))
                   && range_bad)
          || ((in_q.op == sfcs_pkg::OP_SERASE) && sector_bad)) begin
        res_d.status = sfcs_pkg::ST_REJECTED;
      end else if (in_q.op == sfcs_pkg::OP_READ) begin
        res_d.tx_valid = 1'b1;
        res_d.tx_byte  = sfcs_pkg::OPC_READ;
      end else begin
        res_d.tx_valid   = 1'b1;
        res_d.tx_byte    = sfcs_pkg::OPC_WREN;
        res_d.cs_release = 1'b1;
      end
    end else begin
      case (phase_q)
        sfcs_pkg::PH_WREN: begin
          res_d.tx_valid = 1'b1;
          if (cmd_kind_q == sfcs_pkg::OP_CERASE) begin
            res_d.tx_byte    = sfcs_pkg::OPC_CERASE;
            res_d.cs_release = 1'b1;
          end else begin
            res_d.tx_byte = sfcs_pkg::opcode_of(cmd_kind_q);
          end
        end
        sfcs_pkg::PH_HDR: begin
          if (hdr_index_q != 2'd3) begin
            res_d.tx_valid = 1'b1;
            case (hdr_inc)
              2'd1:    res_d.tx_byte = 8'(cur_addr_q >> 16);
              2'd2:    res_d.tx_byte = cur_addr_q[15:8];
              default: res_d.tx_byte = cur_addr_q[7:0];
            endcase
            if (hdr_inc == 2'd3) begin
              if ((cmd_kind_q == sfcs_pkg::OP_SERASE) || bl_zero) begin
                res_d.cs_release = 1'b1;
              end else if (cmd_kind_q == sfcs_pkg::OP_PROG) begin
                res_d.need_data = 1'b1;
              end
            end
          end else if (cmd_kind_q == sfcs_pkg::OP_READ) begin
            if (bl_zero) begin
              res_d.status = sfcs_pkg::ST_DONE;
            end else begin
              res_d.tx_valid   = 1'b1;
              res_d.tx_byte    = sfcs_pkg::FILL_BYTE;
              res_d.cs_release = bl_dec == '0;
            end
          end else if (prog_more) begin
            res_d.tx_valid   = 1'b1;
            res_d.tx_byte    = in_q.wr_data;
            res_d.cs_release = data_last;
            res_d.need_data  = !data_last;
          end else begin
            res_d.tx_valid = 1'b1;
            res_d.tx_byte  = sfcs_pkg::OPC_RDSR;
          end
        end
        sfcs_pkg::PH_READ: begin
          res_d.read_valid = 1'b1;
          res_d.rd_data    = in_q.rx_byte;
          if (bl_zero) begin
            res_d.status = sfcs_pkg::ST_DONE;
          end else begin
            res_d.tx_valid   = 1'b1;
            res_d.tx_byte    = sfcs_pkg::FILL_BYTE;
            res_d.cs_release = bl_dec == '0;
          end
        end
        sfcs_pkg::PH_PDATA: begin
          res_d.tx_valid   = 1'b1;
          res_d.tx_byte    = in_q.wr_data;
          res_d.cs_release = data_last;
          res_d.need_data  = !data_last;
        end
        sfcs_pkg::PH_FEND: begin
          res_d.tx_valid = 1'b1;
          res_d.tx_byte  = sfcs_pkg::OPC_RDSR;
        end
        sfcs_pkg::PH_WCMD: begin
          res_d.tx_valid = 1'b1;
          res_d.tx_byte  = sfcs_pkg::FILL_BYTE;
        end
        sfcs_pkg::PH_WPOLL: begin
          if (in_q.rx_byte[0]) begin
            res_d.tx_valid = 1'b1;
            res_d.tx_byte  = sfcs_pkg::FILL_BYTE;
          end else begin
            res_d.cs_release = 1'b1;
            res_d.status     = prog_more ? sfcs_pkg::ST_BUSY : sfcs_pkg::ST_DONE;
          end
        end
        sfcs_pkg::PH_REOPEN: begin
          res_d.tx_valid   = 1'b1;
          res_d.tx_byte    = sfcs_pkg::OPC_WREN;
          res_d.cs_release = 1'b1;
        end
        default: res_d.status = sfcs_pkg::ST_IGNORED;
      endcase
    end
  end

  assign rsp_o.valid      = out_vld_q;
  assign rsp_o.tx_valid   = out_q.tx_valid;
  assign rsp_o.tx_byte    = out_q.tx_byte;
  assign rsp_o.cs_release = out_q.cs_release;
  assign rsp_o.need_data  = out_q.need_data;
  assign rsp_o.read_valid = out_q.read_valid;
  assign rsp_o.rd_data    = out_q.rd_data;
  assign rsp_o.status     = out_q.status;

`ifndef NO_ASSERTIONS
  a_reject_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (res_d.status == sfcs_pkg::ST_REJECTED)
    |=> (phase_q == $past(phase_q)) && (cur_addr_q == $past(cur_addr_q))
        && (bytes_left_q == $past(bytes_left_q)))
    else $error("rejected request changed command state");

  a_done_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (res_d.status == sfcs_pkg::ST_DONE) |=> phase_q == sfcs_pkg::PH_IDLE)
    else $error("completed command left sequencer busy");

  a_exchange_no_growth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && in_q.mode |=> bytes_left_q <= $past(bytes_left_q))
    else $error("byte count grew on an exchange");

  a_empty_stage_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vld_q |-> req_i.ready)
    else $error("empty request stage not ready");
`endif

endmodule
